// ----- sv/imu_to_can_speed_yaw_encoder_macros.svh -----
// Assertion macros shared by the speed/yaw encoder RTL.
// Only files that carry concurrent checks include this header.
`ifndef IMU_TO_CAN_SPEED_YAW_ENCODER_MACROS_SVH
`define IMU_TO_CAN_SPEED_YAW_ENCODER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ICS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ICS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ICS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ICS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/ics_pkg.sv -----
// Shared widths, constants and types of the speed/yaw CAN frame encoder.
// No dependencies; used by every module of the block.
package ics_pkg;

	localparam int VEL_W      = 18;
	localparam int HEAD_W     = 20;
	localparam int DIFF_W     = HEAD_W + 1;
	localparam int MAG_W      = 20;
	localparam int ID_W       = 11;
	localparam int RATE_W     = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 80;
	localparam int PAYLOAD_W   = 32;
	localparam int SPEED_W     = 16;
	localparam int YAW_W       = 15;

	// shared multiplier
	localparam int MUL_W  = 24;
	localparam int PROD_W = 2 * MUL_W;

	// speed path: S = ve^2 + vn^2, radicand = S * 1296
	localparam int SQ_W    = 35;
	localparam int SUMSQ_W = 36;
	localparam int RAD_W   = 46;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 2;

	// x/100 = (x * ceil(2^30/100)) >> 30, exact for x < 2^23
	localparam logic [MUL_W-1:0] RECIP_100 = 24'd10737419;
	localparam int               SHIFT_100 = 30;
	// x/10 = (x * ceil(2^22/10)) >> 22, exact for x < 2^19
	localparam logic [MUL_W-1:0] RECIP_10  = 24'd419431;
	localparam int               SHIFT_10  = 22;
	localparam int               YAW_P_W   = MAG_W + RATE_W;
	localparam int               YAW_Q_W   = 19;
	// |d| * rate at or above this gives yaw > 32767
	localparam logic [YAW_P_W-1:0] YAW_SAT_LIM = 30'd327680;

	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
	localparam logic [YAW_W-1:0]   YAW_MAX   = '1;

	localparam logic signed [DIFF_W-1:0] HALF_TURN     = 21'sd180000;
	localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -21'sd180000;
	localparam logic signed [DIFF_W-1:0] FULL_TURN     = 21'sd360000;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'd1;
	localparam logic [ID_W-1:0]      FRAME_ID_RST    = 11'h4F8;
	localparam logic [RATE_W-1:0]    RATE_RST        = 10'd100;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [VEL_W-1:0]         ve_mag;
		logic [VEL_W-1:0]         vn_mag;
		logic signed [DIFF_W-1:0] dhead;
	} ics_job_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload_low;
		logic [ID_W-1:0]      message_id;
	} ics_frame_t;

endpackage

// ----- sv/ics_queue.sv -----
// Small FIFO of classified samples between front and back.
// Depends on ics_pkg for the item type.
module ics_queue #(
	parameter int DEPTH = ics_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  ics_pkg::ics_job_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output ics_pkg::ics_job_t pop_data
);
	import ics_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ics_job_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/ics_front.sv -----
// Input side: takes samples, drops the first one after reset into the heading
// register, forms velocity magnitudes and the raw heading step. Uses ics_pkg.
module ics_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ics_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                          job_valid,
	input  logic                          job_ready,
	output ics_pkg::ics_job_t             job
);
	import ics_pkg::*;

	logic                     have_prev_q;
	logic signed [HEAD_W-1:0] prev_head_q;
	logic signed [VEL_W-1:0]  ve;
	logic signed [VEL_W-1:0]  vn;
	logic signed [HEAD_W-1:0] hd;
	logic                     accept;

	assign ve = s_tdata[VEL_W-1:0];
	assign vn = s_tdata[2*VEL_W-1:VEL_W];
	assign hd = s_tdata[2*VEL_W+HEAD_W-1:2*VEL_W];

	assign s_tready  = job_ready;
	assign accept    = s_tvalid && s_tready;
	// first sample only primes the heading register
	assign job_valid = s_tvalid && have_prev_q;

	always_comb begin
		// -(-2^17) is 2^17, still fits unsigned in VEL_W bits
		job.ve_mag = ve[VEL_W-1] ? (~ve + 1'b1) : ve;
		job.vn_mag = vn[VEL_W-1] ? (~vn + 1'b1) : vn;
		job.dhead  = DIFF_W'(hd) - DIFF_W'(prev_head_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_head_q <= '0;
		end else if (accept) begin
			have_prev_q <= 1'b1;
			prev_head_q <= hd;
		end
	end

endmodule

// ----- sv/ics_back.sv -----
// Execution side: sequencer around one shared multiplier and a bit-serial
// square root, plus the output register. Uses ics_pkg and the assertion macros.
`include "imu_to_can_speed_yaw_encoder_macros.svh"

module ics_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  ics_pkg::ics_job_t         job,
	input  logic [ics_pkg::ID_W-1:0]   frame_id,
	input  logic [ics_pkg::RATE_W-1:0] sample_rate_hz,
	output logic                      out_valid,
	input  logic                      out_ready,
	output ics_pkg::ics_frame_t       out_frame
);
	import ics_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQE   = 4'd1;
	localparam logic [3:0] ST_SQN   = 4'd2;
	localparam logic [3:0] ST_SCALE = 4'd3;
	localparam logic [3:0] ST_YAW1  = 4'd4;
	localparam logic [3:0] ST_YAW2  = 4'd5;
	localparam logic [3:0] ST_YAW3  = 4'd6;
	localparam logic [3:0] ST_ROOT  = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	localparam int              ITER_W    = $clog2(ROOT_W);
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_W - 1);

	logic [3:0]               state_q;
	logic [ITER_W-1:0]        iter_q;
	logic                     out_valid_q;
	ics_frame_t               out_frame_q;

	logic [VEL_W-1:0]         ve_q;
	logic [VEL_W-1:0]         vn_q;
	logic signed [DIFF_W-1:0] d_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     sign_q;
	logic [SQ_W-1:0]          sum_q;
	logic [PROD_W-1:0]        prod_q;
	logic [RAD_W-1:0]         rad_q;
	logic [REM_W-1:0]         rem_q;
	logic [ROOT_W-1:0]        root_q;
	logic                     ysat_q;
	logic [YAW_W-1:0]         yaw_q;

	logic [MUL_W-1:0]         mul_a;
	logic [MUL_W-1:0]         mul_b;
	logic [PROD_W-1:0]        mul_p;
	logic [SUMSQ_W-1:0]       sum_sq;
	logic [RAD_W-1:0]         sum_ext;
	logic [RAD_W-1:0]         rad_scaled;
	logic signed [DIFF_W-1:0] d_neg;
	logic [REM_W+1:0]         rem_sh;
	logic [REM_W+1:0]         trial;
	logic                     root_bit;
	logic [REM_W+1:0]         rem_sub;
	logic [ROOT_W:0]          root_x2;
	logic [YAW_P_W-1:0]       yaw_p;
	logic [SPEED_W-1:0]       speed;
	logic                     fin_go;

	// one multiplier, operands chosen by the sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQE: begin
				mul_a = MUL_W'(ve_q);
				mul_b = MUL_W'(ve_q);
			end
			ST_SQN: begin
				mul_a = MUL_W'(vn_q);
				mul_b = MUL_W'(vn_q);
			end
			ST_YAW1: begin
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(sample_rate_hz);
			end
			ST_YAW2: begin
				mul_a = MUL_W'(prod_q[YAW_Q_W-1:0]);
				mul_b = RECIP_10;
			end
			ST_DIV: begin
				mul_a = MUL_W'(root_q);
				mul_b = RECIP_100;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// 1296 = 1024 + 256 + 16
	assign sum_sq     = SUMSQ_W'(sum_q) + SUMSQ_W'(prod_q[SQ_W-1:0]);
	assign sum_ext    = RAD_W'(sum_sq);
	assign rad_scaled = (sum_ext << 10) + (sum_ext << 8) + (sum_ext << 4);
	assign d_neg      = -d_q;

	// one root digit per cycle
	assign rem_sh   = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign root_bit = (rem_sh >= trial);
	assign rem_sub  = rem_sh - trial;
	assign root_x2  = {root_q, 1'b0};

	assign yaw_p = prod_q[YAW_P_W-1:0];
	assign speed = (|prod_q[PROD_W-1:SHIFT_100+SPEED_W]) ? SPEED_MAX
		: prod_q[SHIFT_100 +: SPEED_W];

	assign job_ready = (state_q == ST_IDLE);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_frame = out_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_SQE;
					end
				end
				ST_SQE:   state_q <= ST_SQN;
				ST_SQN:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_YAW1;
				ST_YAW1:  state_q <= ST_YAW2;
				ST_YAW2:  state_q <= ST_YAW3;
				ST_YAW3: begin
					state_q <= ST_ROOT;
					iter_q  <= '0;
				end
				ST_ROOT: begin
					if (iter_q == ITER_LAST) begin
						state_q <= ST_DIV;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_DIV: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					ve_q <= job.ve_mag;
					vn_q <= job.vn_mag;
					d_q  <= job.dhead;
				end
			end
			ST_SQE: begin
				prod_q <= mul_p;
				if (d_q < NEG_HALF_TURN) begin
					d_q <= d_q + FULL_TURN;
				end
			end
			ST_SQN: begin
				prod_q <= mul_p;
				sum_q  <= prod_q[SQ_W-1:0];
				if (d_q > HALF_TURN) begin
					d_q <= d_q - FULL_TURN;
				end
			end
			ST_SCALE: begin
				rad_q  <= rad_scaled;
				sign_q <= ~d_q[DIFF_W-1];
				mag_q  <= d_q[DIFF_W-1] ? d_neg[MAG_W-1:0] : d_q[MAG_W-1:0];
			end
			ST_YAW1: prod_q <= mul_p;
			ST_YAW2: begin
				ysat_q <= (yaw_p >= YAW_SAT_LIM);
				prod_q <= mul_p;
			end
			ST_YAW3: begin
				yaw_q  <= ysat_q ? YAW_MAX : prod_q[SHIFT_10 +: YAW_W];
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= root_bit ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], root_bit};
			end
			ST_DIV: prod_q <= mul_p;
			ST_FIN: begin
				if (fin_go) begin
					out_frame_q.message_id  <= frame_id;
					out_frame_q.payload_low <= {sign_q, yaw_q, speed};
				end
			end
			default: begin
			end
		endcase
	end

	`ICS_ASSERT_NXT(a_root_stay, clk, arst_n, state_q == ST_ROOT && iter_q != ITER_LAST, state_q == ST_ROOT, "root sequence left early")
	`ICS_ASSERT_NXT(a_root_done, clk, arst_n, state_q == ST_ROOT && iter_q == ITER_LAST, state_q == ST_DIV, "root sequence overran")
	`ICS_ASSERT_IMP(a_rem_bound, clk, arst_n, state_q == ST_ROOT, rem_q <= root_x2, "root remainder above twice the partial root")
	`ICS_ASSERT_IMP(a_yaw_range, clk, arst_n, state_q == ST_YAW3 && !ysat_q, prod_q[PROD_W-1:SHIFT_10+YAW_W] == '0, "unsaturated yaw exceeds 15 bits")

endmodule

// ----- sv/imu_to_can_speed_yaw_encoder.sv -----
// Top level of the navigation-sample to CAN speed/yaw frame encoder:
// config registers, front, queue and back. Uses ics_pkg, ics_front, ics_queue, ics_back.
//
// channel   dir   fields
// s_*       in    tdata: vel_east[17:0] vel_north[35:18] heading_mdeg[55:36]
// m_*       out   tdata: message_id[10:0] payload_low[42:11] payload_high[74:43]
// cfg_*     in    index 0 frame_id, index 1 sample_rate_hz
//
// The back end takes one frame at a time: the accept step, six setup steps
// (squares, scaling, yaw multiply and divide), one step per root digit, the
// divide by 100 and the output step.
// The first sample after reset is accepted but gives no frame.
// The input queue holds QUEUE_DEPTH samples, so input is still taken, until the queue
// is full, while a finished frame waits on m_tready. Reset is asynchronous, active low.
module imu_to_can_speed_yaw_encoder #(
	parameter int QUEUE_DEPTH = ics_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// vel_east, vel_north, heading_mdeg
	input  logic [ics_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// message_id, payload_low, payload_high, zero fill
	output logic [ics_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ics_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ics_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ics_pkg::*;

	logic [ID_W-1:0]   frame_id_q;
	logic [RATE_W-1:0] sample_rate_q;
	logic              push_valid;
	logic              push_ready;
	ics_job_t          push_job;
	logic              pop_valid;
	logic              pop_ready;
	ics_job_t          pop_job;
	ics_frame_t        frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q    <= FRAME_ID_RST;
			sample_rate_q <= RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_ID:    frame_id_q    <= cfg_data[ID_W-1:0];
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ics_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job       (push_job)
	);

	ics_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_job)
	);

	ics_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (pop_valid),
		.job_ready      (pop_ready),
		.job            (pop_job),
		.frame_id       (frame_id_q),
		.sample_rate_hz (sample_rate_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_frame      (frame)
	);

	// bytes 4..7 of the frame are always zero
	assign m_tdata = {5'b0, {PAYLOAD_W{1'b0}}, frame.payload_low, frame.message_id};

endmodule
